### src/wret_pkg.sv
// Shared types, constants and helper functions of the windowed rate tracker.
// Used by the ring memory, the serial divider and the top level; no dependencies.
package wret_pkg;

	localparam int HISTORY_DEPTH = 10;
	localparam int SLOT_W        = $clog2(HISTORY_DEPTH);
	localparam int FILL_W        = $clog2(HISTORY_DEPTH + 1);

	localparam int COUNTER_W = 40;
	localparam int TIME_W    = 48;
	localparam int RATE_W    = 50;
	localparam int ALPHA_W   = 7;

	localparam int DIV_N_W   = RATE_W + ALPHA_W;
	localparam int DIV_D_W   = TIME_W;
	localparam int DIV_CNT_W = $clog2(DIV_N_W + 1);

	// Division of the blended sum by one hundred, one chunk of the dividend per
	// step. The remainder and the next chunk stay below 2^26, where the
	// reciprocal multiplication below is exact.
	localparam int CHUNK_W      = 19;
	localparam int DIV100_STEPS = DIV_N_W / CHUNK_W;
	localparam int DIV100_CNT_W = $clog2(DIV100_STEPS);
	localparam int STEP_W       = CHUNK_W + ALPHA_W;
	localparam int RECIP_W      = 27;
	localparam int RECIP_SHIFT  = 33;
	localparam int PROD_W       = STEP_W + RECIP_W;

	localparam logic [ALPHA_W-1:0] ALPHA_RESET  = ALPHA_W'(30);
	localparam logic [ALPHA_W-1:0] PERCENT_FULL = ALPHA_W'(100);
	localparam logic [RATE_W-1:0]  RATE_SCALE   = RATE_W'(1000);
	localparam logic [RATE_W-1:0]  RATE_MAX     = {RATE_W{1'b1}};
	localparam logic [RECIP_W-1:0] RECIP_100    = RECIP_W'(85899346);

	typedef struct packed {
		logic [TIME_W-1:0]    sample_time;
		logic [COUNTER_W-1:0] second_count;
		logic [COUNTER_W-1:0] first_count;
	} entry_t;

	typedef struct packed {
		logic               start;
		logic [DIV_N_W-1:0] dividend;
		logic [DIV_D_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic               busy;
		logic               done;
		logic [DIV_N_W-1:0] quotient;
	} div_rsp_t;

	typedef enum logic {
		OP_RATE1 = 1'b0,
		OP_RATE2 = 1'b1
	} div_op_t;

	function automatic logic [COUNTER_W-1:0] abs_diff(input logic [COUNTER_W-1:0] a,
			input logic [COUNTER_W-1:0] b);
		return (a >= b) ? (a - b) : (b - a);
	endfunction

	// The product stays below 2^50 for any 40-bit magnitude.
	function automatic logic [RATE_W-1:0] scale_rate(input logic [COUNTER_W-1:0] mag);
		return RATE_W'(mag) * RATE_SCALE;
	endfunction

	function automatic logic [RATE_W-1:0] sat_rate(input logic [DIV_N_W-1:0] q);
		return (q > DIV_N_W'(RATE_MAX)) ? RATE_MAX : q[RATE_W-1:0];
	endfunction

	function automatic logic [ALPHA_W-1:0] clamp_alpha(input logic [ALPHA_W-1:0] a);
		return (a > PERCENT_FULL) ? PERCENT_FULL : a;
	endfunction

	// Weighted sum before the division by one hundred; below 100 * 2^50.
	function automatic logic [DIV_N_W-1:0] blend_sum(input logic [RATE_W-1:0] rate,
			input logic [RATE_W-1:0] avg, input logic [ALPHA_W-1:0] a);
		logic [ALPHA_W-1:0] b;
		b = PERCENT_FULL - a;
		return DIV_N_W'(a) * DIV_N_W'(rate) + DIV_N_W'(b) * DIV_N_W'(avg);
	endfunction

	// One step of the long division by one hundred. Returns the quotient chunk
	// above the new remainder.
	function automatic logic [STEP_W-1:0] div100_step(input logic [ALPHA_W-1:0] rem,
			input logic [CHUNK_W-1:0] chunk);
		logic [STEP_W-1:0]  num;
		logic [PROD_W-1:0]  prod;
		logic [CHUNK_W-1:0] quo;
		logic [STEP_W-1:0]  left;
		num  = {rem, chunk};
		prod = PROD_W'(num) * PROD_W'(RECIP_100);
		quo  = prod[RECIP_SHIFT +: CHUNK_W];
		left = num - STEP_W'(quo) * STEP_W'(PERCENT_FULL);
		return {quo, left[ALPHA_W-1:0]};
	endfunction

endpackage

### src/wret_ring_mem.sv
// Sample history ring: one write port and one registered read port.
// Depends on wret_pkg for the entry type and the ring depth.
module wret_ring_mem
	import wret_pkg::*;
(
	input  logic              clk,
	input  logic              wr_en,
	input  logic [SLOT_W-1:0] wr_addr,
	input  entry_t            wr_data,
	input  logic              rd_en,
	input  logic [SLOT_W-1:0] rd_addr,
	output entry_t            rd_data
);

	entry_t mem_q [HISTORY_DEPTH];
	entry_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

### src/wret_div.sv
// Restoring serial divider, one quotient bit per cycle.
// Depends on wret_pkg for the request and response structs.
module wret_div
	import wret_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] count_q;
	logic [DIV_N_W-1:0]   acc_q;
	logic [DIV_D_W-1:0]   rem_q;
	logic [DIV_D_W-1:0]   den_q;

	logic [DIV_D_W:0]   rem_shift;
	logic [DIV_D_W:0]   rem_diff;
	logic               fits;
	logic [DIV_D_W-1:0] rem_next;

	// The partial remainder stays below the divisor, so the difference fits.
	assign rem_shift = {rem_q, acc_q[DIV_N_W-1]};
	assign rem_diff  = rem_shift - {1'b0, den_q};
	assign fits      = rem_shift >= {1'b0, den_q};
	assign rem_next  = fits ? rem_diff[DIV_D_W-1:0] : rem_shift[DIV_D_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			count_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q  <= 1'b1;
				count_q <= DIV_CNT_W'(DIV_N_W);
			end else if (busy_q) begin
				count_q <= count_q - 1'b1;
				if (count_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// The dividend shifts out at the top while quotient bits enter at the bottom.
	always_ff @(posedge clk) begin
		if (req.start) begin
			acc_q <= req.dividend;
			rem_q <= '0;
			den_q <= req.divisor;
		end else if (busy_q) begin
			acc_q <= {acc_q[DIV_N_W-2:0], fits};
			rem_q <= rem_next;
		end
	end

	assign rsp.busy     = busy_q;
	assign rsp.done     = done_q;
	assign rsp.quotient = acc_q;

endmodule

### src/windowed_rate_ema_tracker.sv
// Windowed rate-of-change tracker with exponential smoothing: top level.
// Depends on wret_pkg, wret_ring_mem and wret_div.
//
// Usage. Each sample transaction (sample_valid, sample_stall) carries two
// 40-bit counter readings and a 48-bit millisecond timestamp. Every sample
// yields exactly one result transaction (result_valid, result_stall) with the
// smoothed per-second rates of both counters and rates_valid, which goes high
// once the first rate has been computed; until then both averages read zero.
// The smoothing weight in percent is written through cfg_valid/cfg_ready with
// the data on smoothing_percent; cfg_ready is always high, and writes belong
// in idle periods only. Values above 100 act as 100.
//
// Operation. One sample is processed at a time. A first sample or one with equal
// timestamps needs no division, the seeding sample no blend. The serial divider
// runs each division by the time span, a 57-bit quotient, once per counter; the
// blend is then divided by one hundred one 19-bit chunk at a time.
// The result is held in an output register, so a new sample is taken while
// a stalled result waits; the next result waits in turn until it is taken.
// Reset empties the history ring (its memory needs no clearing, as only
// written slots are read), clears the averages and sets the weight to 30.
module windowed_rate_ema_tracker
	import wret_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 sample_valid,
	output logic                 sample_stall,
	input  logic [COUNTER_W-1:0] first_counter,
	input  logic [COUNTER_W-1:0] second_counter,
	input  logic [TIME_W-1:0]    sample_time_ms,
	output logic                 result_valid,
	input  logic                 result_stall,
	output logic [RATE_W-1:0]    first_rate_avg,
	output logic [RATE_W-1:0]    second_rate_avg,
	output logic                 rates_valid,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [ALPHA_W-1:0]   smoothing_percent
);

	typedef enum logic [6:0] {
		ST_IDLE   = 7'b0000001,
		ST_FETCH  = 7'b0000010,
		ST_PREP   = 7'b0000100,
		ST_DIVIDE = 7'b0001000,
		ST_MIX    = 7'b0010000,
		ST_SCALE  = 7'b0100000,
		ST_OUT    = 7'b1000000
	} state_t;

	state_t state_q;
	div_op_t op_q;

	// Configuration register.
	logic [ALPHA_W-1:0] alpha_q;

	// Ring bookkeeping and the smoothed averages.
	logic [SLOT_W-1:0] write_slot_q;
	logic [FILL_W-1:0] filled_q;
	logic [RATE_W-1:0] avg1_q;
	logic [RATE_W-1:0] avg2_q;
	logic              seeded_q;

	// Working registers of the sample under way.
	entry_t             newest_q;
	logic [TIME_W-1:0]  span_q;
	logic [COUNTER_W-1:0] mag1_q;
	logic [COUNTER_W-1:0] mag2_q;
	logic [RATE_W-1:0]  rate1_q;
	logic [RATE_W-1:0]  rate2_q;
	logic [DIV_N_W-1:0] sum1_q;
	logic [DIV_N_W-1:0] sum2_q;
	logic [ALPHA_W-1:0] rem1_q;
	logic [ALPHA_W-1:0] rem2_q;
	logic [DIV100_CNT_W-1:0] chunk_q;

	// Output register.
	logic              result_valid_q;
	logic [RATE_W-1:0] first_rate_avg_q;
	logic [RATE_W-1:0] second_rate_avg_q;
	logic              rates_valid_q;

	logic              accept;
	logic              out_load;
	logic [SLOT_W-1:0] slot_next;
	logic [FILL_W-1:0] filled_next;
	logic [SLOT_W-1:0] oldest_addr;
	entry_t            sample_entry;
	entry_t            oldest_entry;
	logic [TIME_W-1:0] span;
	logic [ALPHA_W-1:0] alpha_eff;
	logic [RATE_W-1:0] quot_sat;
	logic [STEP_W-1:0] step1;
	logic [STEP_W-1:0] step2;
	logic [DIV_N_W-1:0] sum1_shift;
	logic [DIV_N_W-1:0] sum2_shift;
	div_req_t          div_req;
	div_rsp_t          div_rsp;

	assign cfg_ready    = 1'b1;
	assign sample_stall = (state_q != ST_IDLE);
	assign accept       = sample_valid && !sample_stall;
	assign out_load     = (state_q == ST_OUT) && (!result_valid_q || !result_stall);

	assign sample_entry.sample_time  = sample_time_ms;
	assign sample_entry.second_count = second_counter;
	assign sample_entry.first_count  = first_counter;

	assign slot_next   = (write_slot_q == SLOT_W'(HISTORY_DEPTH - 1)) ? '0 : write_slot_q + 1'b1;
	assign filled_next = (filled_q == FILL_W'(HISTORY_DEPTH)) ? filled_q : filled_q + 1'b1;

	// While the ring is filling, the oldest sample is the first one written,
	// in slot zero. Once it is full, the oldest is the slot written next.
	assign oldest_addr = (filled_next < FILL_W'(HISTORY_DEPTH)) ? '0 : slot_next;

	wret_ring_mem u_ring (
		.clk     (clk),
		.wr_en   (accept),
		.wr_addr (write_slot_q),
		.wr_data (sample_entry),
		.rd_en   (accept),
		.rd_addr (oldest_addr),
		.rd_data (oldest_entry)
	);

	// The span wraps at 48 bits should the timestamps ever go backwards.
	assign span      = newest_q.sample_time - oldest_entry.sample_time;
	assign alpha_eff = clamp_alpha(alpha_q);
	assign quot_sat  = sat_rate(div_rsp.quotient);

	// Long division of the blended sums by one hundred: the top chunk is divided
	// each cycle and the quotient chunk enters at the bottom as the sum shifts up.
	assign step1      = div100_step(rem1_q, sum1_q[DIV_N_W-1 -: CHUNK_W]);
	assign step2      = div100_step(rem2_q, sum2_q[DIV_N_W-1 -: CHUNK_W]);
	assign sum1_shift = {sum1_q[DIV_N_W-CHUNK_W-1:0], step1[STEP_W-1 -: CHUNK_W]};
	assign sum2_shift = {sum2_q[DIV_N_W-CHUNK_W-1:0], step2[STEP_W-1 -: CHUNK_W]};

	always_comb begin
		div_req.start = (state_q == ST_PREP);
		case (op_q)
			OP_RATE1: begin
				div_req.dividend = DIV_N_W'(scale_rate(mag1_q));
				div_req.divisor  = span_q;
			end
			OP_RATE2: begin
				div_req.dividend = DIV_N_W'(scale_rate(mag2_q));
				div_req.divisor  = span_q;
			end
			default: begin
				div_req.dividend = '0;
				div_req.divisor  = '0;
			end
		endcase
	end

	wret_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Sequencer: write the sample and fetch the oldest, take the span and the
	// magnitudes, run the two rate divisions, blend and divide by one hundred, or
	// seed the averages with the first rate, then hand over the result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			op_q         <= OP_RATE1;
			alpha_q      <= ALPHA_RESET;
			write_slot_q <= '0;
			filled_q     <= '0;
			avg1_q       <= '0;
			avg2_q       <= '0;
			seeded_q     <= 1'b0;
			chunk_q      <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				alpha_q <= smoothing_percent;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						write_slot_q <= slot_next;
						filled_q     <= filled_next;
						state_q      <= (filled_next >= FILL_W'(2)) ? ST_FETCH : ST_OUT;
					end
				end
				ST_FETCH: begin
					op_q <= OP_RATE1;
					// Equal timestamps give no rate; the averages are held.
					state_q <= (span == '0) ? ST_OUT : ST_PREP;
				end
				ST_PREP: begin
					state_q <= ST_DIVIDE;
				end
				ST_DIVIDE: begin
					if (div_rsp.done) begin
						case (op_q)
							OP_RATE1: begin
								op_q    <= OP_RATE2;
								state_q <= ST_PREP;
							end
							OP_RATE2: begin
								if (seeded_q) begin
									state_q <= ST_MIX;
								end else begin
									avg1_q   <= rate1_q;
									avg2_q   <= quot_sat;
									seeded_q <= 1'b1;
									state_q  <= ST_OUT;
								end
							end
							default: begin
								state_q <= ST_OUT;
							end
						endcase
					end
				end
				ST_MIX: begin
					chunk_q <= '0;
					state_q <= ST_SCALE;
				end
				ST_SCALE: begin
					chunk_q <= chunk_q + 1'b1;
					if (chunk_q == DIV100_CNT_W'(DIV100_STEPS - 1)) begin
						avg1_q  <= sum1_shift[RATE_W-1:0];
						avg2_q  <= sum2_shift[RATE_W-1:0];
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			newest_q <= sample_entry;
		end
		if (state_q == ST_FETCH) begin
			span_q <= span;
			mag1_q <= abs_diff(newest_q.first_count, oldest_entry.first_count);
			mag2_q <= abs_diff(newest_q.second_count, oldest_entry.second_count);
		end
		if ((state_q == ST_DIVIDE) && div_rsp.done) begin
			if (op_q == OP_RATE1) begin
				rate1_q <= quot_sat;
			end
			if (op_q == OP_RATE2) begin
				rate2_q <= quot_sat;
			end
		end
		if (state_q == ST_MIX) begin
			sum1_q <= blend_sum(rate1_q, avg1_q, alpha_eff);
			sum2_q <= blend_sum(rate2_q, avg2_q, alpha_eff);
			rem1_q <= '0;
			rem2_q <= '0;
		end
		if (state_q == ST_SCALE) begin
			sum1_q <= sum1_shift;
			sum2_q <= sum2_shift;
			rem1_q <= step1[ALPHA_W-1:0];
			rem2_q <= step2[ALPHA_W-1:0];
		end
	end

	// Output register: the result waits here while the receiver stalls.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (out_load) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			first_rate_avg_q  <= avg1_q;
			second_rate_avg_q <= avg2_q;
			rates_valid_q     <= seeded_q;
		end
	end

	assign result_valid    = result_valid_q;
	assign first_rate_avg  = first_rate_avg_q;
	assign second_rate_avg = second_rate_avg_q;
	assign rates_valid     = rates_valid_q;

`ifndef SYNTHESIS
	// The ring fills from slot zero, so until it is full the write slot
	// equals the number of stored samples.
	a_fill_tracks_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(filled_q != FILL_W'(HISTORY_DEPTH)) |-> (FILL_W'(write_slot_q) == filled_q))
		else $error("write slot and fill count disagree while the ring fills");

	// A division is only started once the previous one has finished.
	a_div_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> !div_rsp.busy)
		else $error("divider started while busy");

	// A new result appears only after the sequencer has reached hand-over.
	a_result_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(state_q == ST_OUT))
		else $error("result presented outside hand-over");

	// Before any rate exists both averages read zero.
	a_unseeded_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !rates_valid) |-> (first_rate_avg == '0 && second_rate_avg == '0))
		else $error("non-zero average before the first rate");
`endif

endmodule

### tb/rate_ema_scoreboard_pkg.sv
// Scoreboard of the windowed rate tracker testbench. It predicts the smoothed
// rates for each accepted sample transaction and checks each result against them.
// Depends on wret_pkg for widths and constants.
package rate_ema_scoreboard_pkg;
	import wret_pkg::*;

	typedef struct {
		logic [RATE_W-1:0] first_avg;
		logic [RATE_W-1:0] second_avg;
		logic              seeded;
	} rate_avg_t;

	class rate_ema_scoreboard;
		logic [COUNTER_W-1:0] first_ring [HISTORY_DEPTH];
		logic [COUNTER_W-1:0] second_ring [HISTORY_DEPTH];
		logic [TIME_W-1:0]    time_ring [HISTORY_DEPTH];
		int                   next_slot;
		int                   filled;
		logic [RATE_W-1:0]    first_avg;
		logic [RATE_W-1:0]    second_avg;
		logic                 seeded;
		logic [ALPHA_W-1:0]   weight;
		rate_avg_t            pending_avgs [$];
		int                   errors;
		int                   samples;
		int                   checked;
		int                   zero_spans;
		int                   updates;

		function new();
			next_slot  = 0;
			filled     = 0;
			first_avg  = '0;
			second_avg = '0;
			seeded     = 1'b0;
			weight     = ALPHA_RESET;
			errors     = 0;
			samples    = 0;
			checked    = 0;
			zero_spans = 0;
			updates    = 0;
		endfunction

		function void set_weight(logic [ALPHA_W-1:0] value);
			weight = value;
		endfunction

		function int pending_count();
			return pending_avgs.size();
		endfunction

		// Counts per second between two samples of one counter over the window.
		function logic [RATE_W-1:0] window_rate(logic [COUNTER_W-1:0] newer,
				logic [COUNTER_W-1:0] older, logic [TIME_W-1:0] span);
			logic [63:0] mag;
			logic [63:0] quot;
			mag  = (newer >= older) ? 64'(newer - older) : 64'(older - newer);
			quot = mag * 64'(RATE_SCALE) / 64'(span);
			return (quot > 64'(RATE_MAX)) ? RATE_MAX : quot[RATE_W-1:0];
		endfunction

		// Weights above one hundred per cent are treated as exactly one hundred.
		function logic [RATE_W-1:0] smooth(logic [RATE_W-1:0] rate, logic [RATE_W-1:0] avg);
			logic [63:0] a;
			logic [63:0] weighted;
			a        = (weight > PERCENT_FULL) ? 64'(PERCENT_FULL) : 64'(weight);
			weighted = a * 64'(rate) + (64'(PERCENT_FULL) - a) * 64'(avg);
			return RATE_W'(weighted / 64'(PERCENT_FULL));
		endfunction

		function void note_sample(logic [COUNTER_W-1:0] first_count,
				logic [COUNTER_W-1:0] second_count, logic [TIME_W-1:0] stamp);
			int                newest;
			int                oldest;
			logic [TIME_W-1:0] span;
			logic [RATE_W-1:0] first_rate;
			logic [RATE_W-1:0] second_rate;
			rate_avg_t         expected;
			newest = next_slot;
			first_ring[newest]  = first_count;
			second_ring[newest] = second_count;
			time_ring[newest]   = stamp;
			next_slot = (newest + 1) % HISTORY_DEPTH;
			if (filled < HISTORY_DEPTH) begin
				filled++;
			end
			if (filled >= 2) begin
				// While the ring is filling, the window reaches back to the very first sample.
				oldest = (filled < HISTORY_DEPTH) ? 0 : next_slot;
				span   = time_ring[newest] - time_ring[oldest];
				if (span == '0) begin
					zero_spans++;
				end else begin
					first_rate  = window_rate(first_ring[newest], first_ring[oldest], span);
					second_rate = window_rate(second_ring[newest], second_ring[oldest], span);
					if (seeded) begin
						first_avg  = smooth(first_rate, first_avg);
						second_avg = smooth(second_rate, second_avg);
						updates++;
					end else begin
						first_avg  = first_rate;
						second_avg = second_rate;
						seeded     = 1'b1;
					end
				end
			end
			expected.first_avg  = first_avg;
			expected.second_avg = second_avg;
			expected.seeded     = seeded;
			pending_avgs.push_back(expected);
			samples++;
		endfunction

		function void check_averages(logic [RATE_W-1:0] first_rate_avg,
				logic [RATE_W-1:0] second_rate_avg, logic rates_valid);
			rate_avg_t expected;
			if (pending_avgs.size() == 0) begin
				$error("result transaction with no sample outstanding");
				errors++;
				return;
			end
			expected = pending_avgs.pop_front();
			checked++;
			if (first_rate_avg !== expected.first_avg) begin
				$error("first_rate_avg: expected %0d, got %0d", expected.first_avg, first_rate_avg);
				errors++;
			end
			if (second_rate_avg !== expected.second_avg) begin
				$error("second_rate_avg: expected %0d, got %0d", expected.second_avg,
					second_rate_avg);
				errors++;
			end
			if (rates_valid !== expected.seeded) begin
				$error("rates_valid: expected %0d, got %0d", expected.seeded, rates_valid);
				errors++;
			end
		endfunction
	endclass

endpackage

### tb/windowed_rate_ema_tracker_tb.sv
// Top level of the windowed rate tracker testbench: clock, reset, sample and
// result drivers, smoothing weight writes and the final verdict.
// Depends on wret_pkg, rate_ema_scoreboard_pkg and the windowed_rate_ema_tracker RTL.
module windowed_rate_ema_tracker_tb;
	import wret_pkg::*;
	import rate_ema_scoreboard_pkg::*;

	localparam logic [COUNTER_W-1:0] COUNT_MAX = {COUNTER_W{1'b1}};
	localparam logic [TIME_W-1:0]    TIME_MAX  = {TIME_W{1'b1}};
	localparam int PHASES        = 8;
	localparam int PHASE_SAMPLES = 210;
	// This comfortably covers one more smoothed update.
	localparam int DRAIN_CYCLES  = 300;
	// The weights of the random phases: both ends, the values just around one
	// hundred per cent, and a few ordinary ones.
	localparam logic [ALPHA_W-1:0] PHASE_WEIGHTS [PHASES] =
		'{7'd0, 7'd100, 7'd127, 7'd1, 7'd50, 7'd101, 7'd99, 7'd30};

	logic                 clk               = 1'b0;
	logic                 arst_n            = 1'b0;
	logic                 sample_valid      = 1'b0;
	logic                 sample_stall;
	logic [COUNTER_W-1:0] first_counter     = '0;
	logic [COUNTER_W-1:0] second_counter    = '0;
	logic [TIME_W-1:0]    sample_time_ms    = '0;
	logic                 result_valid;
	logic                 result_stall      = 1'b0;
	logic [RATE_W-1:0]    first_rate_avg;
	logic [RATE_W-1:0]    second_rate_avg;
	logic                 rates_valid;
	logic                 cfg_valid         = 1'b0;
	logic                 cfg_ready;
	logic [ALPHA_W-1:0]   smoothing_percent = ALPHA_RESET;

	rate_ema_scoreboard sb;

	// When steady is set, neither side idles, so the block runs back to back.
	bit                   steady     = 1'b0;
	int                   stall_left = 0;
	int                   run_left   = 0;
	int                   freeze_left = 0;
	logic [COUNTER_W-1:0] first_now  = '0;
	logic [COUNTER_W-1:0] second_now = '0;
	logic [TIME_W-1:0]    now_ms     = '0;

	windowed_rate_ema_tracker dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.sample_valid      (sample_valid),
		.sample_stall      (sample_stall),
		.first_counter     (first_counter),
		.second_counter    (second_counter),
		.sample_time_ms    (sample_time_ms),
		.result_valid      (result_valid),
		.result_stall      (result_stall),
		.first_rate_avg    (first_rate_avg),
		.second_rate_avg   (second_rate_avg),
		.rates_valid       (rates_valid),
		.cfg_valid         (cfg_valid),
		.cfg_ready         (cfg_ready),
		.smoothing_percent (smoothing_percent)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// The slowest correct run is about 1700 samples, each taking at most one smoothed
	// update of work plus the longest sender gap and the longest result stall. The
	// limit allows nearly four times that worst case.
	initial begin
		#50_000_000;
		$display("FAIL windowed_rate_ema_tracker");
		$finish;
	end

	// Idle lengths for both sides: mostly none or short, now and then long enough
	// to span a whole division or more.
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 55) return 0;
		if (roll < 85) return $urandom_range(1, 3);
		if (roll < 97) return $urandom_range(4, 25);
		return $urandom_range(60, 300);
	endfunction

	// Counters mostly creep upwards, sometimes leap, sometimes restart from near
	// zero and sometimes take an arbitrary value, so that every bit is exercised.
	function automatic logic [COUNTER_W-1:0] next_count(logic [COUNTER_W-1:0] prev);
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 75) return prev + COUNTER_W'($urandom_range(0, 200000));
		if (roll < 85) return prev + COUNTER_W'({$urandom, $urandom});
		if (roll < 92) return COUNTER_W'($urandom_range(0, 1000));
		return COUNTER_W'({$urandom, $urandom});
	endfunction

	// Result side. The check uses the values present at the edge; the stall for
	// the next cycle is chosen in the same step and only takes effect after it.
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			sb.check_averages(first_rate_avg, second_rate_avg, rates_valid);
		end
		if (steady) begin
			result_stall <= 1'b0;
			stall_left = 0;
			run_left   = 0;
		end else if (stall_left != 0) begin
			result_stall <= 1'b1;
			stall_left--;
		end else if (run_left != 0) begin
			result_stall <= 1'b0;
			run_left--;
		end else begin
			result_stall <= 1'b0;
			stall_left = pick_gap();
			run_left   = $urandom_range(0, 40);
		end
	end

	// One sample transaction: an optional gap with valid low, then the payload is
	// held steady until the block stops stalling. Valid is raised only here and
	// lowered only for a gap, a weight write or the end, never twice in a step.
	task automatic send_sample(logic [COUNTER_W-1:0] first_count,
			logic [COUNTER_W-1:0] second_count, logic [TIME_W-1:0] stamp);
		int gap;
		gap = steady ? 0 : pick_gap();
		if (gap != 0) begin
			sample_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample_valid   <= 1'b1;
		first_counter  <= first_count;
		second_counter <= second_count;
		sample_time_ms <= stamp;
		do @(posedge clk); while (sample_stall);
		sb.note_sample(first_count, second_count, stamp);
	endtask

	// Every sample gives one result, so the block is idle once the last expected
	// result has been taken; a few spare cycles are added all the same.
	task automatic drain(int extra);
		while (sb.pending_count() != 0) @(posedge clk);
		repeat (extra) @(posedge clk);
	endtask

	task automatic write_weight(logic [ALPHA_W-1:0] value);
		sample_valid <= 1'b0;
		drain(8);
		cfg_valid         <= 1'b1;
		smoothing_percent <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.set_weight(value);
	endtask

	// Polling-style traffic. Time usually advances by up to a few seconds, but it
	// also sits idle for long stretches, jumps anywhere in the 48-bit range, steps
	// backwards, and occasionally freezes for long enough that the whole window
	// shares one timestamp.
	task automatic random_samples(int count);
		int roll;
		repeat (count) begin
			roll = $urandom_range(0, 99);
			if (freeze_left != 0) begin
				freeze_left--;
			end else if (roll < 2) begin
				freeze_left = $urandom_range(5, 14);
			end else if (roll < 72) begin
				now_ms = now_ms + TIME_W'($urandom_range(1, 5000));
			end else if (roll < 88) begin
				now_ms = now_ms + TIME_W'($urandom);
			end else if (roll < 94) begin
				now_ms = TIME_W'({$urandom, $urandom});
			end else if (roll < 97) begin
				now_ms = now_ms - TIME_W'($urandom_range(1, 100000));
			end
			first_now  = next_count(first_now);
			second_now = next_count(second_now);
			send_sample(first_now, second_now, now_ms);
		end
	endtask

	initial begin
		sb = new();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, at the reset weight of 30 per cent. The first sample
		// cannot give a rate, and a repeated timestamp before any rate exists
		// must leave the averages at zero.
		send_sample('0, COUNT_MAX, 48'd1000);
		send_sample(40'd5, COUNT_MAX - 40'd5, 48'd1000);
		// Full-scale change over one millisecond seeds the averages with the
		// largest rate there is.
		send_sample(COUNT_MAX, '0, 48'd1001);
		// Back to the first timestamp: the window spans no time, so the averages hold.
		send_sample(COUNT_MAX, 40'd7, 48'd1000);
		send_sample(40'd12345, 40'd67890, 48'd2000);
		// Time running backwards wraps the span to almost the full 48-bit range.
		send_sample('0, '0, 48'd500);
		// Fill the ring and run two samples past it, so the window start moves on.
		for (int i = 1; i <= 6; i++) begin
			send_sample(COUNTER_W'(i * 1000), COUNTER_W'(i * 37), TIME_W'(2000 + i * 250));
		end
		send_sample(40'd9000, 40'd500, TIME_MAX);
		send_sample(40'd9100, 40'd600, TIME_MAX);
		// Timestamp wrapping through zero.
		send_sample(40'd9200, 40'd700, 48'd3);
		first_now  = 40'd9200;
		second_now = 40'd700;
		now_ms     = 48'd3;

		for (int p = 0; p < PHASES; p++) begin
			write_weight(PHASE_WEIGHTS[p]);
			steady = (p == 2 || p == 5);
			random_samples(PHASE_SAMPLES);
		end
		steady = 1'b0;

		sample_valid <= 1'b0;
		drain(DRAIN_CYCLES);
		$display("Covered %0d samples and %0d results: %0d smoothed updates, %0d zero-span holds.",
			sb.samples, sb.checked, sb.updates, sb.zero_spans);
		$display("Weights from 0 to 127 over %0d phases, with and without idling on both sides.",
			PHASES);
		if (sb.errors == 0) begin
			$display("PASS windowed_rate_ema_tracker");
		end else begin
			$display("FAIL windowed_rate_ema_tracker");
		end
		$finish;
	end

endmodule
